@@ hw/rtl/ptlk_pkg.sv @@
`default_nettype none
package ptlk_pkg;
    localparam int unsigned TableLen = 24;
    localparam int unsigned CordW = 34;
    localparam int unsigned ZW = 33;
    localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
    localparam logic [1:0] CfgLink1 = 2'd0;
    localparam logic [1:0] CfgLink2 = 2'd1;

    typedef logic signed [CordW-1:0] t_cord;
    typedef logic signed [ZW-1:0] t_zang;

    typedef struct packed {
        t_cord x;
        t_cord y;
        t_zang z;
    } t_rot;

    function automatic t_zang atan_entry(input int unsigned i);
        t_zang v;
        case (i)
            0: v = 33'sh020000000;
            1: v = 33'sh012E4051D;
            2: v = 33'sh009FB385B;
            3: v = 33'sh0051111D4;
            4: v = 33'sh0028B0D43;
            5: v = 33'sh00145D7E1;
            6: v = 33'sh000A2F61E;
            7: v = 33'sh000517C55;
            8: v = 33'sh00028BE53;
            9: v = 33'sh000145F2E;
            10: v = 33'sh0000A2F98;
            11: v = 33'sh0000517CC;
            12: v = 33'sh000028BE6;
            13: v = 33'sh0000145F3;
            14: v = 33'sh00000A2F9;
            15: v = 33'sh00000517C;
            16: v = 33'sh0000028BE;
            17: v = 33'sh00000145F;
            18: v = 33'sh000000A2F;
            19: v = 33'sh000000517;
            20: v = 33'sh00000028B;
            21: v = 33'sh000000145;
            22: v = 33'sh0000000A2;
            23: v = 33'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/ptlk_cordic_cell.sv @@
`default_nettype none
module ptlk_cordic_cell #(
    parameter int unsigned STAGE = 0
) (
    input  wire logic            i_clk,
    input  wire ptlk_pkg::t_rot  i_a,
    input  wire ptlk_pkg::t_rot  i_b,
    input  wire logic [1:0]      i_ka,
    input  wire logic [1:0]      i_kb,
    output ptlk_pkg::t_rot       o_a,
    output ptlk_pkg::t_rot       o_b,
    output logic [1:0]           o_ka,
    output logic [1:0]           o_kb
);
    import ptlk_pkg::*;

    t_rot r_a, r_b;
    logic [1:0] r_ka, r_kb;
    t_rot n_a, n_b;

    function automatic t_rot rot(input t_rot v);
        t_rot o;
        t_cord dx, dy;
        dx = v.y >>> STAGE;
        dy = v.x >>> STAGE;
        if (!v.z[ZW-1]) begin
            o.x = v.x - dx;
            o.y = v.y + dy;
            o.z = v.z - atan_entry(STAGE);
        end else begin
            o.x = v.x + dx;
            o.y = v.y - dy;
            o.z = v.z + atan_entry(STAGE);
        end
        return o;
    endfunction

    always_comb begin
        n_a = rot(i_a);
        n_b = rot(i_b);
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_ka <= i_ka;
        r_kb <= i_kb;
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_ka = r_ka;
    assign o_kb = r_kb;
endmodule
`default_nettype wire

@@ hw/rtl/planar_two_link_kinematics_unit.sv @@
`default_nettype none
// planar two-link arm: tip position, jacobian and tip velocity
// requests enter on start when busy is low; busy is never raised,
// so one request may be given every cycle
// the user writes link lengths on cfg channel (index 0 link1, 1 link2)
// only while no request is in flight (unenforced); o_cfg_ready always high
// 1 input stage, CORDIC_STAGES cordic cells (at most TableLen), then 5
// stages of quadrant/rounding, length products, sums, rate products and
// output rounding
// throughput: one request per cycle, set by the row of cordic cells that
// hands the rotation of both angles on each cycle
// each result is shown for one cycle with o_done high; the receiver
// cannot stall, so nothing is held back
// reset (synchronous, active low) clears the valid pipe and sets link
// lengths to 1.0 and 0.7
module planar_two_link_kinematics_unit #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [0:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    input  wire logic [15:0]         i_joint1_angle,
    input  wire logic [15:0]         i_joint2_angle,
    input  wire logic signed [15:0]  i_joint1_rate,
    input  wire logic signed [15:0]  i_joint2_rate,
    output logic                     o_done,
    output logic signed [17:0]       o_tip_x,
    output logic signed [17:0]       o_tip_y,
    output logic signed [17:0]       o_jac_xq1,
    output logic signed [17:0]       o_jac_xq2,
    output logic signed [17:0]       o_jac_yq1,
    output logic signed [17:0]       o_jac_yq2,
    output logic signed [21:0]       o_tip_vx,
    output logic signed [21:0]       o_tip_vy
);
    import ptlk_pkg::*;

    localparam int unsigned NS = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;
    localparam int unsigned LAT = NS + 6;

    logic [15:0] r_len1, r_len2;
    logic [LAT-1:0] r_vld;
    logic signed [15:0] r_w1 [LAT-2];
    logic signed [15:0] r_w2 [LAT-2];

    t_rot c_a [NS+1];
    t_rot c_b [NS+1];
    logic [1:0] c_ka [NS+1];
    logic [1:0] c_kb [NS+1];

    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len1 <= 16'd4096;
            r_len2 <= 16'd2867;
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
            if (i_cfg_valid && o_cfg_ready) begin
                if ({1'b0, i_cfg_index} == CfgLink1) r_len1 <= i_cfg_data;
                if ({1'b0, i_cfg_index} == CfgLink2) r_len2 <= i_cfg_data;
            end
        end
    end

    // angle reduction into cell row input
    function automatic logic [1:0] quad(input logic [15:0] a);
        logic [15:0] t;
        t = a + 16'd8192;
        return t[15:14];
    endfunction

    function automatic t_rot seed(input logic [15:0] a);
        t_rot o;
        logic [15:0] r;
        r = a - {quad(a), 14'd0};
        o.x = CordicGain;
        o.y = '0;
        o.z = {{1{r[15]}}, r, 16'd0};
        return o;
    endfunction

    t_rot r_sa, r_sb;
    logic [1:0] r_ka0, r_kb0;
    logic [15:0] n_sum;
    assign n_sum = i_joint1_angle + i_joint2_angle;

    always_ff @(posedge i_clk) begin
        r_sa <= seed(i_joint1_angle);
        r_sb <= seed(n_sum);
        r_ka0 <= quad(i_joint1_angle);
        r_kb0 <= quad(n_sum);
        r_w1[0] <= i_joint1_rate;
        r_w2[0] <= i_joint2_rate;
        for (int i = 1; i < LAT - 2; i++) begin
            r_w1[i] <= r_w1[i-1];
            r_w2[i] <= r_w2[i-1];
        end
    end

    assign c_a[0] = r_sa;
    assign c_b[0] = r_sb;
    assign c_ka[0] = r_ka0;
    assign c_kb[0] = r_kb0;

    for (genvar g = 0; g < NS; g++) begin : g_cell
        ptlk_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk),
            .i_a(c_a[g]), .i_b(c_b[g]), .i_ka(c_ka[g]), .i_kb(c_kb[g]),
            .o_a(c_a[g+1]), .o_b(c_b[g+1]), .o_ka(c_ka[g+1]), .o_kb(c_kb[g+1])
        );
    end

    // quadrant and rounding to 16 fractional bits
    function automatic logic signed [19:0] rnd14(input logic signed [CordW:0] v);
        logic signed [CordW:0] t;
        t = v + (CordW+1)'(8192);
        return t[33:14];
    endfunction

    function automatic logic signed [39:0] fold(input t_rot v, input logic [1:0] k);
        logic signed [CordW:0] x, y, c, s;
        x = {v.x[CordW-1], v.x};
        y = {v.y[CordW-1], v.y};
        case (k)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        return {rnd14(c), rnd14(s)};
    endfunction

    logic signed [19:0] r_c1, r_s1, r_c12, r_s12;
    always_ff @(posedge i_clk) begin
        {r_c1, r_s1} <= fold(c_a[NS], c_ka[NS]);
        {r_c12, r_s12} <= fold(c_b[NS], c_kb[NS]);
    end

    // length products, q.28
    logic signed [36:0] r_p1c, r_p1s, r_p2c, r_p2s;
    always_ff @(posedge i_clk) begin
        r_p1c <= 37'($signed({1'b0, r_len1}) * r_c1);
        r_p1s <= 37'($signed({1'b0, r_len1}) * r_s1);
        r_p2c <= 37'($signed({1'b0, r_len2}) * r_c12);
        r_p2s <= 37'($signed({1'b0, r_len2}) * r_s12);
    end

    logic signed [37:0] r_xs, r_ys, r_jx2, r_jy2;
    always_ff @(posedge i_clk) begin
        r_xs <= 38'(r_p1c) + 38'(r_p2c);
        r_ys <= 38'(r_p1s) + 38'(r_p2s);
        r_jx2 <= -38'(r_p2s);
        r_jy2 <= 38'(r_p2c);
    end

    logic signed [53:0] r_m1, r_m2, r_m3, r_m4;
    logic signed [37:0] r_xs2, r_ys2, r_jx22, r_jy22;
    always_ff @(posedge i_clk) begin
        r_m1 <= 54'(-r_ys * r_w1[LAT-3]);
        r_m2 <= 54'(r_jx2 * r_w2[LAT-3]);
        r_m3 <= 54'(r_xs * r_w1[LAT-3]);
        r_m4 <= 54'(r_jy2 * r_w2[LAT-3]);
        r_xs2 <= r_xs;
        r_ys2 <= r_ys;
        r_jx22 <= r_jx2;
        r_jy22 <= r_jy2;
    end

    function automatic logic signed [17:0] out18(input logic signed [37:0] v);
        logic signed [38:0] t;
        logic signed [22:0] q;
        t = 39'(v) + 39'sd32768;
        q = t[38:16];
        if (q > 23'sd131071) return 18'sd131071;
        if (q < -23'sd131072) return -18'sd131072;
        return q[17:0];
    endfunction

    function automatic logic signed [21:0] out22(input logic signed [54:0] v);
        logic signed [54:0] t;
        logic signed [26:0] q;
        t = v + 55'sd134217728;
        q = t[54:28];
        if (q > 27'sd2097151) return 22'sd2097151;
        if (q < -27'sd2097152) return -22'sd2097152;
        return q[21:0];
    endfunction

    always_ff @(posedge i_clk) begin
        o_tip_x <= out18(r_xs2);
        o_tip_y <= out18(r_ys2);
        o_jac_xq1 <= out18(-r_ys2);
        o_jac_xq2 <= out18(r_jx22);
        o_jac_yq1 <= out18(r_xs2);
        o_jac_yq2 <= out18(r_jy22);
        o_tip_vx <= out22(55'(r_m1) + 55'(r_m2));
        o_tip_vy <= out22(55'(r_m3) + 55'(r_m4));
    end

    assign o_done = r_vld[LAT-1];

    a_busy_low: assert property (@(posedge i_clk) busy == 1'b0)
        else $error("busy raised");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_vld[LAT-2]))
        else $error("done without request");
    a_jac_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_jac_yq1 == o_tip_x))
        else $error("jacobian and position disagree");
endmodule
`default_nettype wire
